/* rtl/sha_bsh_pkg.sv */
// Package for the SHA-256 byte stream hasher: round constants, initial hash
// values, SHA-256 helper functions and controller/datapath types.
// Has no dependencies.
`default_nettype none

package sha_bsh_pkg;

   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned FILL_W     = $clog2(BLOCK_BYTES);
   localparam int unsigned LEN_START  = 56;
   localparam logic [7:0]  PAD_MARK   = 8'h80;

   typedef logic [7:0][31:0] hash_words_type;

   localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // index 0 is word a / H0
   localparam hash_words_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_COMPRESS,
      ST_FOLD,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                push;
      byte_src_type        src;
      logic                count_bits;
      logic                load_work;
      logic                round;
      logic [ROUND_W-1:0]  round_idx;
      logic                fold;
      logic                finish;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_len;
   } dp_status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

/* rtl/sha_bsh_ctrl.sv */
// Controller for the SHA-256 byte stream hasher: sequences byte loading,
// padding, compression rounds and digest output. Uses sha_bsh_pkg.
`default_nettype none

module sha_bsh_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_byte_present,
   input  wire logic                       req_last_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output sha_bsh_pkg::dp_cmd_type         cmd,
   input  wire sha_bsh_pkg::dp_status_type status
);
   import sha_bsh_pkg::*;

   state_type           state_ff, state_in;
   state_type           resume_ff, resume_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_present && status.fill_last) begin
                  state_in  = ST_COMPRESS;
                  resume_in = req_last_byte ? ST_PAD_ONE : ST_IDLE;
               end else if (req_last_byte) begin
                  state_in = ST_PAD_ONE;
               end
            end
         end
         ST_PAD_ONE: begin
            if (status.fill_last) begin
               state_in  = ST_COMPRESS;
               resume_in = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            priority if (status.fill_len) begin
               state_in = ST_PAD_LEN;
            end else if (status.fill_last) begin
               state_in  = ST_COMPRESS;
               resume_in = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            if (status.fill_last) begin
               state_in  = ST_COMPRESS;
               resume_in = ST_OUTPUT;
            end
         end
         ST_COMPRESS: begin
            if (round_ff == ROUND_W'(NUM_ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = resume_ff;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.src       = SRC_DATA;
      cmd.round_idx = round_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && req_byte_present) begin
               cmd.push       = 1'b1;
               cmd.count_bits = 1'b1;
               cmd.load_work  = status.fill_last;
            end
         end
         ST_PAD_ONE: begin
            cmd.push      = 1'b1;
            cmd.src       = SRC_MARK;
            cmd.load_work = status.fill_last;
         end
         ST_PAD_ZERO: begin
            cmd.src = SRC_ZERO;
            if (!status.fill_len) begin
               cmd.push      = 1'b1;
               cmd.load_work = status.fill_last;
            end
         end
         ST_PAD_LEN: begin
            cmd.push      = 1'b1;
            cmd.src       = SRC_LEN;
            cmd.load_work = status.fill_last;
         end
         ST_COMPRESS: begin
            cmd.round = 1'b1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_OUTPUT: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      round_in = (state_ff == ST_COMPRESS) ? round_ff + 1'b1 : '0;
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resume_ff    <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/sha_bsh_dp.sv */
// Datapath for the SHA-256 byte stream hasher: block/schedule window, working
// variables, chaining value, bit count and digest output register.
// Uses sha_bsh_pkg.
`default_nettype none

module sha_bsh_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sha_bsh_pkg::dp_cmd_type    cmd,
   output sha_bsh_pkg::dp_status_type      status,
   input  wire logic [7:0]                 req_data_byte,
   output logic [63:0]                     rsp_digest_word0,
   output logic [63:0]                     rsp_digest_word1,
   output logic [63:0]                     rsp_digest_word2,
   output logic [63:0]                     rsp_digest_word3
);
   import sha_bsh_pkg::*;

   logic [511:0]        window_ff, window_in;
   hash_words_type      work_ff, work_in;
   hash_words_type      chain_ff, chain_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [63:0]         bits_ff, bits_in;
   logic [255:0]        digest_ff;

   logic [7:0]          push_byte;
   logic [7:0]          len_byte;
   logic [31:0]         w_cur;
   logic [31:0]         w_next;
   logic [31:0]         t1;
   logic [31:0]         t2;

   assign status.fill_last = (fill_ff == FILL_W'(BLOCK_BYTES - 1));
   assign status.fill_len  = (fill_ff == FILL_W'(LEN_START));

   // length bytes go out most significant first
   assign len_byte = 8'(bits_ff >> {~fill_ff[2:0], 3'b000});

   always_comb begin
      unique case (cmd.src)
         SRC_DATA: push_byte = req_data_byte;
         SRC_MARK: push_byte = PAD_MARK;
         SRC_ZERO: push_byte = 8'h00;
         SRC_LEN:  push_byte = len_byte;
         default:  push_byte = 8'h00;
      endcase
   end

   // window word j sits at [511-32j -: 32]
   assign w_cur  = window_ff[511:480];
   assign w_next = small_sigma1(window_ff[63:32]) + window_ff[223:192] +
                   small_sigma0(window_ff[479:448]) + window_ff[511:480];

   assign t1 = work_ff[7] + big_sigma1(work_ff[4]) +
               ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6])) +
               ROUND_K[cmd.round_idx] + w_cur;
   assign t2 = big_sigma0(work_ff[0]) +
               ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                (work_ff[1] & work_ff[2]));

   always_comb begin
      window_in = window_ff;
      work_in   = work_ff;
      chain_in  = chain_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      if (cmd.push) begin
         window_in = {window_ff[503:0], push_byte};
         fill_in   = fill_ff + 1'b1;
      end
      if (cmd.count_bits) begin
         bits_in = bits_ff + 64'd8;
      end
      if (cmd.load_work) begin
         work_in = chain_ff;
      end
      if (cmd.round) begin
         window_in  = {window_ff[479:0], w_next};
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.finish) begin
         chain_in = INIT_HASH;
         fill_in  = '0;
         bits_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      work_ff   <= work_in;
      if (cmd.finish) begin
         digest_ff <= {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3],
                       chain_ff[4], chain_ff[5], chain_ff[6], chain_ff[7]};
      end
   end

   assign rsp_digest_word0 = digest_ff[255:192];
   assign rsp_digest_word1 = digest_ff[191:128];
   assign rsp_digest_word2 = digest_ff[127:64];
   assign rsp_digest_word3 = digest_ff[63:0];

endmodule

`default_nettype wire

/* rtl/sha256_byte_stream_hasher_core.sv */
// SHA-256 byte stream hasher, top level.
// Usage:
//  - req channel: one word per message byte (req_byte_present), req_last_byte
//    closes the message; a closing word without a byte is allowed, so empty
//    messages hash too. A word with neither flag is taken and ignored.
//  - rsp channel: one word per message, the 256-bit digest as four 64-bit
//    big-endian words, first digest byte in the top bits of word 0.
//  - A byte word is taken whenever req_ready is high. Every 64th byte starts a compression
//    of 64 rounds, one round per cycle, then a fold step adds the result into the
//    chaining value; req_ready is low during the rounds and the fold, so no
//    new byte is taken until the compression of a block is through.
//  - Closing a message pads one byte per cycle, apart from any compression in
//    between, up to the end of the block (plus a step without a byte before the
//    length bytes), compresses once or twice, then loads the digest register.
//  - The digest sits in an output register; the next message may start while
//    it waits. Only a second digest waits for rsp_ready.
//  - Synchronous reset returns to the initial hash values, empty buffer and
//    zero bit count, with no digest pending.
// Depends on sha_bsh_pkg, sha_bsh_ctrl and sha_bsh_dp.
`default_nettype none

module sha256_byte_stream_hasher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_word0,
   output logic [63:0]      rsp_digest_word1,
   output logic [63:0]      rsp_digest_word2,
   output logic [63:0]      rsp_digest_word3
);
   import sha_bsh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sha_bsh_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status)
   );

   sha_bsh_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data_byte    (req_data_byte),
      .rsp_digest_word0 (rsp_digest_word0),
      .rsp_digest_word1 (rsp_digest_word1),
      .rsp_digest_word2 (rsp_digest_word2),
      .rsp_digest_word3 (rsp_digest_word3)
   );

endmodule

`default_nettype wire
